// File: hdl/mbt_pkg.sv
// ----------------------------------------------------------------------------
// mbt_pkg
// shared widths, codes, types and step helper for the maze backtracker step core
// ----------------------------------------------------------------------------
package mbt_pkg;

    localparam int COORD_W   = 6;
    localparam int SIZE_W    = 7;
    localparam int EV_W      = 2;
    localparam int DIR_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam int COORD_LIM = 64;

    localparam int DEF_MAX_SIZE    = 64;
    localparam int DEF_STACK_DEPTH = 1024;

    localparam logic [SIZE_W-1:0] SIZE_RST = 7'd21;

    localparam logic [EV_W-1:0] EV_STARTED = 2'd0;
    localparam logic [EV_W-1:0] EV_CARVED  = 2'd1;
    localparam logic [EV_W-1:0] EV_BACK    = 2'd2;
    localparam logic [EV_W-1:0] EV_DONE    = 2'd3;

    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 1'b1;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [COORD_W+1:0] t_wide;

    typedef struct packed {
        t_wide x;
        t_wide y;
    } t_step;

    // one or two squares away in direction d, unsigned with wrap far above the grid
    function automatic t_step step_of(t_coord x, t_coord y, logic [DIR_W-1:0] d,
                                      logic half);
        t_step s;
        t_wide step_len;
        step_len = half ? t_wide'(1) : t_wide'(2);
        s.x  = {2'b00, x};
        s.y  = {2'b00, y};
        case (d)
            DIR_RIGHT: s.x = s.x + step_len;
            DIR_LEFT:  s.x = s.x - step_len;
            DIR_DOWN:  s.y = s.y + step_len;
            DIR_UP:    s.y = s.y - step_len;
            default: begin
            end
        endcase
        return s;
    endfunction

endpackage

// File: hdl/maze_backtracker_step_core.sv
// ----------------------------------------------------------------------------
// maze_backtracker_step_core
// randomised depth-first maze carver, one step per command beat
// ----------------------------------------------------------------------------
// channel   direction  handshake                      payload
// command   in         i_start & !o_busy              i_opcode i_start_x i_start_y
//                                                     i_random_pick
// result    out        o_valid, one cycle             o_pos_x o_pos_y o_wall_x
//                                                     o_wall_y o_event_res
// config    in         i_cfg_valid & o_cfg_ready      i_cfg_index i_cfg_data
//
// advance: one map read per probed direction through the visited-map port;
//   a carve runs probe then mark, a backtrack probe, pop and mark; a search that
//   runs out answers from probe, and an already finished maze answers from idle
// start: a sweep clears the visited map, one entry a cycle, over
//   min(MAX_SIZE,64)^2 entries (4096 at the defaults), then the start cell is marked
// reset leaves the maze finished; no map clear is needed until a start
// results cannot be stalled; config is taken at any time
// ----------------------------------------------------------------------------
module maze_backtracker_step_core #(
    parameter int MAX_SIZE    = mbt_pkg::DEF_MAX_SIZE,
    parameter int STACK_DEPTH = mbt_pkg::DEF_STACK_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic                            i_opcode,
    input  logic [mbt_pkg::COORD_W-1:0]     i_start_x,
    input  logic [mbt_pkg::COORD_W-1:0]     i_start_y,
    input  logic [mbt_pkg::DIR_W-1:0]       i_random_pick,
    output logic                            o_valid,
    output logic [mbt_pkg::COORD_W-1:0]     o_pos_x,
    output logic [mbt_pkg::COORD_W-1:0]     o_pos_y,
    output logic [mbt_pkg::COORD_W-1:0]     o_wall_x,
    output logic [mbt_pkg::COORD_W-1:0]     o_wall_y,
    output logic [mbt_pkg::EV_W-1:0]        o_event_res,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mbt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mbt_pkg::SIZE_W-1:0]      i_cfg_data
);

    import mbt_pkg::*;

    localparam int MAP_W     = (MAX_SIZE < COORD_LIM) ? MAX_SIZE : COORD_LIM;
    localparam int MAP_DEPTH = MAP_W * MAP_W;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam int SAW       = $clog2(STACK_DEPTH);
    localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int STK_W     = 2 * COORD_W;
    localparam int ADDR_WIDE = 2 * COORD_W + 2;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_PROBE = 3'd2;
    localparam logic [2:0] S_POP   = 3'd3;
    localparam logic [2:0] S_MARK  = 3'd4;

    localparam logic [2:0] K_END = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [SIZE_W-1:0] r_size_x, n_size_x;
    logic [SIZE_W-1:0] r_size_y, n_size_y;
    t_coord            r_cur_x, n_cur_x;
    t_coord            r_cur_y, n_cur_y;
    logic              r_fin, n_fin;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [MAP_AW-1:0] r_clr, n_clr;
    logic [DIR_W-1:0]  r_pick, n_pick;
    logic [2:0]        r_k, n_k;
    logic              r_chk, n_chk;
    logic              r_chk_ok, n_chk_ok;
    logic [DIR_W-1:0]  r_chk_dir, n_chk_dir;
    logic [EV_W-1:0]   r_ev, n_ev;
    t_coord            r_wall_x, n_wall_x;
    t_coord            r_wall_y, n_wall_y;
    logic              r_out_valid, n_out_valid;
    t_coord            r_pos_x, n_pos_x;
    t_coord            r_pos_y, n_pos_y;
    t_coord            r_owall_x, n_owall_x;
    t_coord            r_owall_y, n_owall_y;
    logic [EV_W-1:0]   r_oev, n_oev;

    logic [SIZE_W-1:0] eff_x, eff_y;
    logic [DIR_W-1:0]  dir_k;
    t_step             nb_k, nb_c, wl_c;
    logic              nb_ok, found, cur_in_map;
    logic [CNT_W-1:0]  cnt_m1;

    logic              map_we, map_wdata, map_rdata;
    logic [MAP_AW-1:0] map_waddr, map_raddr;
    logic              stk_we;
    logic [STK_W-1:0]  stk_rdata;

    function automatic logic [MAP_AW-1:0] map_addr(t_coord x, t_coord y);
        logic [ADDR_WIDE-1:0] a;
        a = ADDR_WIDE'(y) * ADDR_WIDE'(MAP_W) + ADDR_WIDE'(x);
        return a[MAP_AW-1:0];
    endfunction

    function automatic logic in_grid(t_step s, logic [SIZE_W-1:0] sx,
                                     logic [SIZE_W-1:0] sy);
        logic ok_x, ok_y;
        ok_x = (s.x != '0) && ({1'b0, s.x} + 9'd1 < 9'(sx));
        ok_y = (s.y != '0) && ({1'b0, s.y} + 9'd1 < 9'(sy));
        return ok_x && ok_y;
    endfunction

    assign eff_x = (r_size_x > SIZE_W'(MAP_W)) ? SIZE_W'(MAP_W) : r_size_x;
    assign eff_y = (r_size_y > SIZE_W'(MAP_W)) ? SIZE_W'(MAP_W) : r_size_y;

    assign dir_k = r_pick + r_k[DIR_W-1:0];
    assign nb_k  = step_of(r_cur_x, r_cur_y, dir_k, 1'b0);
    assign nb_ok = in_grid(nb_k, eff_x, eff_y);
    assign nb_c  = step_of(r_cur_x, r_cur_y, r_chk_dir, 1'b0);
    assign wl_c  = step_of(r_cur_x, r_cur_y, r_chk_dir, 1'b1);
    assign found = r_chk && r_chk_ok && !map_rdata;

    assign cur_in_map = ({1'b0, r_cur_x} < SIZE_W'(MAP_W)) &&
                        ({1'b0, r_cur_y} < SIZE_W'(MAP_W));

    assign cnt_m1    = r_cnt - 1'b1;
    assign map_raddr = map_addr(nb_k.x[COORD_W-1:0], nb_k.y[COORD_W-1:0]);

    always_comb begin
        n_state     = r_state;
        n_size_x    = r_size_x;
        n_size_y    = r_size_y;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_fin       = r_fin;
        n_cnt       = r_cnt;
        n_clr       = r_clr;
        n_pick      = r_pick;
        n_k         = r_k;
        n_chk       = r_chk;
        n_chk_ok    = r_chk_ok;
        n_chk_dir   = r_chk_dir;
        n_ev        = r_ev;
        n_wall_x    = r_wall_x;
        n_wall_y    = r_wall_y;
        n_out_valid = 1'b0;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_owall_x   = r_owall_x;
        n_owall_y   = r_owall_y;
        n_oev       = r_oev;
        map_we      = 1'b0;
        map_waddr   = r_clr;
        map_wdata   = 1'b0;
        stk_we      = 1'b0;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SIZE_X: n_size_x = i_cfg_data;
                CFG_SIZE_Y: n_size_y = i_cfg_data;
                default: begin
                end
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_opcode == OP_START) begin
                        n_cur_x  = i_start_x;
                        n_cur_y  = i_start_y;
                        n_cnt    = '0;
                        n_fin    = 1'b0;
                        n_clr    = '0;
                        n_ev     = EV_STARTED;
                        n_wall_x = '0;
                        n_wall_y = '0;
                        n_state  = S_CLEAR;
                    end else if (r_fin) begin
                        n_out_valid = 1'b1;
                        n_pos_x     = r_cur_x;
                        n_pos_y     = r_cur_y;
                        n_owall_x   = '0;
                        n_owall_y   = '0;
                        n_oev       = EV_DONE;
                    end else begin
                        n_pick  = i_random_pick;
                        n_k     = '0;
                        n_chk   = 1'b0;
                        n_state = S_PROBE;
                    end
                end
            end
            S_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = r_clr;
                map_wdata = 1'b0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == MAP_AW'(MAP_DEPTH - 1)) begin
                    n_state = S_MARK;
                end
            end
            S_PROBE: begin
                if (found) begin
                    // open the wall now, the new cell is marked next cycle
                    map_we    = 1'b1;
                    map_waddr = map_addr(wl_c.x[COORD_W-1:0], wl_c.y[COORD_W-1:0]);
                    map_wdata = 1'b1;
                    if (r_cnt < CNT_W'(STACK_DEPTH)) begin
                        stk_we = 1'b1;
                        n_cnt  = r_cnt + 1'b1;
                    end
                    n_cur_x  = nb_c.x[COORD_W-1:0];
                    n_cur_y  = nb_c.y[COORD_W-1:0];
                    n_wall_x = wl_c.x[COORD_W-1:0];
                    n_wall_y = wl_c.y[COORD_W-1:0];
                    n_ev     = EV_CARVED;
                    n_state  = S_MARK;
                end else if (r_k == K_END) begin
                    if (r_cnt != '0) begin
                        n_cnt    = cnt_m1;
                        n_ev     = EV_BACK;
                        n_wall_x = '0;
                        n_wall_y = '0;
                        n_state  = S_POP;
                    end else begin
                        n_fin       = 1'b1;
                        n_out_valid = 1'b1;
                        n_pos_x     = r_cur_x;
                        n_pos_y     = r_cur_y;
                        n_owall_x   = '0;
                        n_owall_y   = '0;
                        n_oev       = EV_DONE;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_chk     = 1'b1;
                    n_chk_ok  = nb_ok;
                    n_chk_dir = dir_k;
                    n_k       = r_k + 1'b1;
                end
            end
            S_POP: begin
                n_cur_x = stk_rdata[COORD_W-1:0];
                n_cur_y = stk_rdata[STK_W-1:COORD_W];
                n_state = S_MARK;
            end
            S_MARK: begin
                map_we      = cur_in_map;
                map_waddr   = map_addr(r_cur_x, r_cur_y);
                map_wdata   = 1'b1;
                n_out_valid = 1'b1;
                n_pos_x     = r_cur_x;
                n_pos_y     = r_cur_y;
                n_owall_x   = r_wall_x;
                n_owall_y   = r_wall_y;
                n_oev       = r_ev;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size_x    <= SIZE_RST;
            r_size_y    <= SIZE_RST;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_fin       <= 1'b1;
            r_cnt       <= '0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_size_x    <= n_size_x;
            r_size_y    <= n_size_y;
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_fin       <= n_fin;
            r_cnt       <= n_cnt;
            r_chk       <= n_chk;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_clr     <= n_clr;
        r_pick    <= n_pick;
        r_k       <= n_k;
        r_chk_ok  <= n_chk_ok;
        r_chk_dir <= n_chk_dir;
        r_ev      <= n_ev;
        r_wall_x  <= n_wall_x;
        r_wall_y  <= n_wall_y;
        r_pos_x   <= n_pos_x;
        r_pos_y   <= n_pos_y;
        r_owall_x <= n_owall_x;
        r_owall_y <= n_owall_y;
        r_oev     <= n_oev;
    end

    mbt_ram #(
        .WIDTH (1),
        .DEPTH (MAP_DEPTH)
    ) u_visited (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    mbt_ram #(
        .WIDTH (STK_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_cnt[SAW-1:0]),
        .i_wdata ({r_cur_y, r_cur_x}),
        .i_raddr (cnt_m1[SAW-1:0]),
        .o_rdata (stk_rdata)
    );

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_pos_x     = r_pos_x;
    assign o_pos_y     = r_pos_y;
    assign o_wall_x    = r_owall_x;
    assign o_wall_y    = r_owall_y;
    assign o_event_res = r_oev;

    a_wall_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_res != EV_CARVED) |-> (o_wall_x == '0) && (o_wall_y == '0))
        else $error("wall reported on a beat that is not a carve");

    a_carve_stack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_res == EV_CARVED) |-> (r_cnt != '0))
        else $error("carve left the path stack empty");

    a_done_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_res == EV_DONE) |-> r_fin)
        else $error("done reported while the maze is not finished");

endmodule

// File: hdl/mbt_ram.sv
// ----------------------------------------------------------------------------
// mbt_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module mbt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
